>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the timer slot table checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define PTST_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define PTST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ptst_pkg.sv
// ----------------------------------------------------------------------------
// ptst_pkg
// Types and constants shared by the periodic timer slot table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ptst_pkg;

  localparam int WORD_W      = 32;
  localparam int SLOT_W      = 5;
  localparam int IDX_W       = 4;
  localparam int IDX_EXT_W   = 7;
  localparam int ARG_N       = 4;
  localparam int MAX_RES     = 16;
  localparam int CNT_W       = 5;
  localparam int IN_TDATA_W  = 200;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 168;
  localparam int OUT_TUSER_W = 3;

  // floor(x / 15) == (x * DIV_MAGIC) >> DIV_SHIFT for every 32-bit x
  localparam logic [WORD_W-1:0] DIV_MAGIC = 32'h8888_8889;
  localparam int                DIV_SHIFT = 35;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_TICK   = 2'd2
  } ptst_req_e;

  typedef enum logic [2:0] {
    KIND_ADDED   = 3'd0,
    KIND_INVALID = 3'd1,
    KIND_FULL    = 3'd2,
    KIND_REMOVED = 3'd3,
    KIND_EXPIRED = 3'd4,
    KIND_NONE    = 3'd5
  } ptst_kind_e;

  typedef struct packed {
    logic [ARG_N-1:0][WORD_W-1:0] args;
    logic [WORD_W-1:0]            period;
    logic [WORD_W-1:0]            handler;
  } ptst_rec_t;

  typedef struct packed {
    logic rec_we;
    logic dl_we;
    logic occ_set;
    logic occ_clr;
  } ptst_wr_t;

  typedef struct packed {
    ptst_kind_e                   kind;
    logic [SLOT_W-1:0]            slot;
    logic [WORD_W-1:0]            handler;
    logic [ARG_N-1:0][WORD_W-1:0] args;
  } ptst_res_t;

  function automatic ptst_res_t make_res(ptst_kind_e kind, logic [SLOT_W-1:0] slot);
    ptst_res_t r;
    r      = '0;
    r.kind = kind;
    r.slot = slot;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ptst_alu.sv
// ----------------------------------------------------------------------------
// ptst_alu
// Shared arithmetic unit: 32-bit add, unsigned compare, reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module ptst_alu (
  input  logic [ptst_pkg::WORD_W-1:0]   opa_i,
  input  logic [ptst_pkg::WORD_W-1:0]   opb_i,
  input  logic [ptst_pkg::WORD_W-1:0]   opc_i,
  output logic [ptst_pkg::WORD_W-1:0]   sum_o,
  output logic                          le_o,
  output logic [2*ptst_pkg::WORD_W-1:0] prod_o
);
  import ptst_pkg::*;

  assign sum_o  = opa_i + opb_i;
  assign le_o   = (opc_i <= opa_i);
  assign prod_o = (2*WORD_W)'(opa_i) * (2*WORD_W)'(DIV_MAGIC);

endmodule

`default_nettype wire

>>> rtl/ptst_store.sv
// ----------------------------------------------------------------------------
// ptst_store
// Slot storage: record and deadline memories plus per-slot occupied bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ptst_store #(
  parameter int SLOT_COUNT = 16,
  parameter int SW         = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ptst_pkg::ptst_wr_t           wr_i,
  input  logic [SW-1:0]                wr_addr_i,
  input  ptst_pkg::ptst_rec_t          rec_i,
  input  logic [ptst_pkg::WORD_W-1:0]  dl_i,
  input  logic [SW-1:0]                rd_addr_i,
  output ptst_pkg::ptst_rec_t          rec_o,
  output logic [ptst_pkg::WORD_W-1:0]  dl_o,
  output logic [SLOT_COUNT-1:0]        occ_o
);
  import ptst_pkg::*;

  ptst_rec_t         rec_mem [SLOT_COUNT];
  logic [WORD_W-1:0] dl_mem  [SLOT_COUNT];
  ptst_rec_t         rec_q;
  logic [WORD_W-1:0] dl_q;
  logic [SLOT_COUNT-1:0] occ_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.rec_we) begin
      rec_mem[wr_addr_i] <= rec_i;
    end
    rec_q <= rec_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.dl_we) begin
      dl_mem[wr_addr_i] <= dl_i;
    end
    dl_q <= dl_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      if (wr_i.occ_set) begin
        occ_q[wr_addr_i] <= 1'b1;
      end
      if (wr_i.occ_clr) begin
        occ_q[wr_addr_i] <= 1'b0;
      end
    end
  end

  assign rec_o = rec_q;
  assign dl_o  = dl_q;
  assign occ_o = occ_q;

endmodule

`default_nettype wire

>>> rtl/periodic_timer_slot_table_top.sv
// ----------------------------------------------------------------------------
// periodic_timer_slot_table_top
// Add: decode, multiply, then a search up from slot 0; the lowest free slot
// is taken. Remove: decode, then the result. Tick: one slot per cycle through
// the shared compare/add unit, held while the output stalls a result.
// Ready returns once the last word is registered.
// Reset: tick count zero, all slots free at once (occupied bits), no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_slot_table_top #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // handler_addr, delay_ms, arg_one, arg_two, arg_three, arg_four, slot_index
  input  logic [ptst_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // req_type
  input  logic [ptst_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // slot_out, handler_out, out_one, out_two, out_three, out_four
  output logic [ptst_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // kind
  output logic [ptst_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
  // last_result
  output logic                             m_axis_tlast
);
  import ptst_pkg::*;

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam logic [CW-1:0]        PTR_END   = CW'(SLOT_COUNT);
  localparam logic [SLOT_W-1:0]    FULL_SLOT = SLOT_W'(SLOT_COUNT);
  localparam logic [IDX_EXT_W-1:0] IDX_LIMIT = IDX_EXT_W'(SLOT_COUNT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_FIND,
    S_SCAN,
    S_FLUSH
  } state_e;

  state_e                       state_q, state_d;
  logic [CW-1:0]                ptr_q, ptr_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [WORD_W-1:0]            tick_q, tick_d;
  logic                         pend_v_q, pend_v_d;
  ptst_res_t                    pend_q, pend_d;
  logic                         out_v_q, out_v_d;
  ptst_res_t                    out_q, out_d;
  logic                         out_last_q, out_last_d;
  logic [2*WORD_W-1:0]          prod_q, prod_d;

  logic [1:0]                   req_q;
  logic [WORD_W-1:0]            handler_q, delay_q;
  logic [ARG_N-1:0][WORD_W-1:0] args_q;
  logic [IDX_W-1:0]             idx_q;

  logic [WORD_W-1:0]     alu_a, alu_b, alu_c, alu_sum;
  logic                  alu_le;
  logic [2*WORD_W-1:0]   alu_prod;
  ptst_wr_t              wr;
  logic [SW-1:0]         wr_addr;
  ptst_rec_t             rec_wr, rec_rd;
  logic [WORD_W-1:0]     dl_rd;
  logic [SLOT_COUNT-1:0] occ;

  logic [SW-1:0]         ptr_idx;
  logic [IDX_EXT_W-1:0]  ptr_ext, idx_ext;
  logic [SLOT_W-1:0]     ptr_slot;
  logic [WORD_W-1:0]     period_new;
  logic                  idx_ok, out_free, fire;

  assign ptr_idx    = ptr_q[SW-1:0];
  assign ptr_ext    = IDX_EXT_W'(ptr_q);
  assign ptr_slot   = ptr_ext[SLOT_W-1:0];
  assign idx_ext    = IDX_EXT_W'(idx_q);
  assign idx_ok     = (idx_ext < IDX_LIMIT);
  assign period_new = WORD_W'(prod_q[2*WORD_W-1:DIV_SHIFT]);
  assign out_free   = !out_v_q || m_axis_tready;
  assign fire       = occ[ptr_idx] && alu_le;

  always_comb begin
    alu_a = (state_q == S_MUL) ? delay_q : tick_q;
    alu_c = dl_rd;
    unique case (state_q)
      S_DECODE: alu_b = WORD_W'(1);
      S_FIND:   alu_b = period_new;
      default:  alu_b = rec_rd.period;
    endcase
  end

  ptst_alu u_alu (
    .opa_i  (alu_a),
    .opb_i  (alu_b),
    .opc_i  (alu_c),
    .sum_o  (alu_sum),
    .le_o   (alu_le),
    .prod_o (alu_prod)
  );

  assign rec_wr = '{args: args_q, period: period_new, handler: handler_q};

  ptst_store #(
    .SLOT_COUNT (SLOT_COUNT),
    .SW         (SW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .wr_addr_i (wr_addr),
    .rec_i     (rec_wr),
    .dl_i      (alu_sum),
    .rd_addr_i (ptr_d[SW-1:0]),
    .rec_o     (rec_rd),
    .dl_o      (dl_rd),
    .occ_o     (occ)
  );

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    cnt_d      = cnt_q;
    tick_d     = tick_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    prod_d     = prod_q;
    out_v_d    = out_v_q && !m_axis_tready;
    out_d      = out_q;
    out_last_d = out_last_q;
    wr         = '0;
    wr_addr    = ptr_idx;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (req_q)
          REQ_ADD: begin
            if (handler_q == '0 || delay_q == '0) begin
              pend_d  = make_res(KIND_INVALID, '0);
              state_d = S_FLUSH;
            end else begin
              state_d = S_MUL;
            end
          end
          REQ_REMOVE: begin
            if (idx_ok) begin
              wr.occ_clr = 1'b1;
              wr_addr    = idx_ext[SW-1:0];
            end
            pend_d  = make_res(KIND_REMOVED, SLOT_W'(idx_q));
            state_d = S_FLUSH;
          end
          REQ_TICK: begin
            tick_d   = alu_sum;
            ptr_d    = '0;
            cnt_d    = '0;
            pend_v_d = 1'b0;
            state_d  = S_SCAN;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_MUL: begin
        prod_d  = alu_prod;
        ptr_d   = '0;
        state_d = S_FIND;
      end
      S_FIND: begin
        priority if (ptr_q == PTR_END) begin
          pend_d  = make_res(KIND_FULL, FULL_SLOT);
          state_d = S_FLUSH;
        end else if (!occ[ptr_idx]) begin
          wr.rec_we  = 1'b1;
          wr.dl_we   = 1'b1;
          wr.occ_set = 1'b1;
          pend_d     = make_res(KIND_ADDED, ptr_slot);
          state_d    = S_FLUSH;
        end else begin
          ptr_d = ptr_q + CW'(1);
        end
      end
      S_SCAN: begin
        priority if (ptr_q == PTR_END || cnt_q == CNT_W'(MAX_RES)) begin
          if (!pend_v_q) begin
            pend_d = make_res(KIND_NONE, '0);
          end
          state_d = S_FLUSH;
        end else if (fire) begin
          if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              out_v_d    = 1'b1;
              out_d      = pend_q;
              out_last_d = 1'b0;
            end
            pend_d   = '{kind: KIND_EXPIRED, slot: ptr_slot, handler: rec_rd.handler,
                         args: rec_rd.args};
            pend_v_d = 1'b1;
            wr.dl_we = 1'b1;
            cnt_d    = cnt_q + CNT_W'(1);
            ptr_d    = ptr_q + CW'(1);
          end
        end else begin
          ptr_d = ptr_q + CW'(1);
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_v_d    = 1'b1;
          out_d      = pend_q;
          out_last_d = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ptr_q      <= '0;
      cnt_q      <= '0;
      tick_q     <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      out_q      <= '0;
      out_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      cnt_q      <= cnt_d;
      tick_q     <= tick_d;
      pend_v_q   <= pend_v_d;
      out_v_q    <= out_v_d;
      out_q      <= out_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    prod_q <= prod_d;
    if (s_axis_tvalid && s_axis_tready) begin
      req_q     <= s_axis_tuser[1:0];
      handler_q <= s_axis_tdata[31:0];
      delay_q   <= s_axis_tdata[63:32];
      args_q[0] <= s_axis_tdata[95:64];
      args_q[1] <= s_axis_tdata[127:96];
      args_q[2] <= s_axis_tdata[159:128];
      args_q[3] <= s_axis_tdata[191:160];
      idx_q     <= s_axis_tdata[195:192];
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_q.args[3], out_q.args[2], out_q.args[1],
                                       out_q.args[0], out_q.handler, out_q.slot});

endmodule

`default_nettype wire

>>> rtl/ptst_checker.sv
// ----------------------------------------------------------------------------
// ptst_checker
// Port-level checks for the periodic timer slot table, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ptst_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [ptst_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [ptst_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
  input logic                             m_axis_tlast
);
  import ptst_pkg::*;

  logic                   in_fire;
  logic                   out_stall;
  logic [OUT_TDATA_W+1:0] out_word;
  logic                   mid_ok;
  logic                   hdl_ok;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tvalid, m_axis_tlast, m_axis_tdata};
  assign mid_ok    = !m_axis_tvalid || m_axis_tlast || (m_axis_tuser == KIND_EXPIRED);
  assign hdl_ok    = !m_axis_tvalid || (m_axis_tuser == KIND_EXPIRED) ||
                     (m_axis_tdata[SLOT_W +: WORD_W] == '0);

  `PTST_ASSERT_ALWAYS(a_rst_no_out, clk_i, !rst_ni |=> !m_axis_tvalid, "output valid in reset")

  `PTST_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_fire |=> !s_axis_tready, "ready after accept")

  `PTST_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> $stable(out_word), "stalled word changed")

  `PTST_ASSERT(a_only_expiry_runs, clk_i, rst_ni, mid_ok, "non-final word not an expiry")

  `PTST_ASSERT(a_zero_handler, clk_i, rst_ni, hdl_ok, "handler set on non-expiry")

endmodule

bind periodic_timer_slot_table_top ptst_checker u_ptst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
